@@ rtl/core/lsf_pkg.sv @@
// ----------------------------------------------------------------------------
// lsf_pkg: shared types and constants for the least-squares line fit
// Holds the shared-unit request/response types, status codes and the
// saturation helper used by the fit datapath.
// ----------------------------------------------------------------------------
package lsf_pkg;

  localparam int DefMaxPoints  = 32;
  localparam int DefCoordWidth = 16;

  // Width of the shared multiply/divide datapath.
  localparam int ArithW = 64;
  // Fraction bits of the slope.
  localparam int SlopeFrac = 16;
  localparam int OutW      = 32;
  localparam int IndexW    = 5;
  localparam int StatusW   = 2;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_DEGEN   = 2'd1,
    STATUS_DROPPED = 2'd2
  } status_e;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } op_e;

  typedef struct packed {
    logic                     start;
    op_e                      op;
    logic signed [ArithW-1:0] a;
    logic signed [ArithW-1:0] b;
  } unit_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [ArithW-1:0] result;
  } unit_rsp_t;

  // Clamp to the signed 32-bit output range.
  function automatic logic signed [OutW-1:0] sat32(input logic signed [ArithW:0] v);
    logic signed [ArithW:0] hi;
    logic signed [ArithW:0] lo;
    hi = (ArithW+1)'(signed'({1'b0, {(OutW-1){1'b1}}}));
    lo = -hi - (ArithW+1)'(1);
    if (v > hi) begin
      return {1'b0, {(OutW-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(OutW-1){1'b0}}};
    end else begin
      return v[OutW-1:0];
    end
  endfunction

endpackage

@@ rtl/core/lsf_seq_unit.sv @@
// ----------------------------------------------------------------------------
// lsf_seq_unit: shared sequential multiply / divide unit
// Signed shift-add multiply and restoring divide, one bit per cycle, both
// truncating toward zero. Product keeps the low ArithW bits.
// ----------------------------------------------------------------------------
module lsf_seq_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lsf_pkg::unit_req_t  req_i,
  output lsf_pkg::unit_rsp_t  rsp_o
);

  localparam int W    = lsf_pkg::ArithW;
  localparam int CW   = $clog2(W);

  logic          busy_q;
  logic          done_q;
  lsf_pkg::op_e  op_q;
  logic          neg_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  ma_q;
  logic [W-1:0]  mb_q;
  logic [W:0]    acc_q;

  logic [W-1:0]  ua;
  logic [W-1:0]  ub;
  logic [W:0]    rem;
  logic [W-1:0]  mag;

  assign ua  = req_i.a[W-1] ? W'(-req_i.a) : W'(req_i.a);
  assign ub  = req_i.b[W-1] ? W'(-req_i.b) : W'(req_i.b);
  assign rem = {acc_q[W-1:0], mb_q[W-1]};
  assign mag = (op_q == lsf_pkg::OP_MUL) ? acc_q[W-1:0] : mb_q;

  assign rsp_o.done   = done_q;
  assign rsp_o.result = neg_q ? signed'(-mag) : signed'(mag);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      op_q  <= req_i.op;
      neg_q <= req_i.a[W-1] ^ req_i.b[W-1];
      acc_q <= '0;
      if (req_i.op == lsf_pkg::OP_MUL) begin
        ma_q <= ua;
        mb_q <= ub;
      end else begin
        ma_q <= ub;
        mb_q <= ua;
      end
    end else if (busy_q) begin
      if (op_q == lsf_pkg::OP_MUL) begin
        if (mb_q[0]) begin
          acc_q <= {1'b0, acc_q[W-1:0] + ma_q};
        end
        ma_q <= {ma_q[W-2:0], 1'b0};
        mb_q <= {1'b0, mb_q[W-1:1]};
      end else begin
        if (rem >= {1'b0, ma_q}) begin
          acc_q <= rem - {1'b0, ma_q};
          mb_q  <= {mb_q[W-2:0], 1'b1};
        end else begin
          acc_q <= rem;
          mb_q  <= {mb_q[W-2:0], 1'b0};
        end
      end
    end
  end

endmodule

@@ rtl/core/least_squares_line_fit.sv @@
// ----------------------------------------------------------------------------
// least_squares_line_fit: ordinary least-squares straight-line fit
// Stores points and their running sums, then fits slope and intercept with
// a shared multiply/divide unit and emits one word per stored point.
// ----------------------------------------------------------------------------
//
//  channel | valid       | stall        | payload
//  --------+-------------+--------------+-------------------------------------
//  input   | in_valid_i  | in_stall_o   | x_value_i, y_value_i, last_point_i
//  output  | out_valid_o | out_stall_i  | point_index_o .. last_result_o
//
// Sequence: a point word is taken each cycle while loading. A word with
// last_point starts the fit: six products and two quotients on the shared
// unit (the quotients are skipped when degenerate), then per stored point a
// memory read and one product (skipped when degenerate) before the result
// word.
// Reset: clears the sums, the count and the sequencer; the point memory
// needs no clearing since only written entries are read.
// Stalls: out_stall_i holds the current result word; input stays stalled
// until the last result word of the set is taken.
// ----------------------------------------------------------------------------
module least_squares_line_fit #(
  parameter int MAX_POINTS  = lsf_pkg::DefMaxPoints,
  parameter int COORD_WIDTH = lsf_pkg::DefCoordWidth
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [COORD_WIDTH-1:0]       x_value_i,
  input  logic signed [COORD_WIDTH-1:0]       y_value_i,
  input  logic                                last_point_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [lsf_pkg::IndexW-1:0]          point_index_o,
  output logic signed [COORD_WIDTH-1:0]       x_echo_o,
  output logic signed [COORD_WIDTH-1:0]       y_observed_o,
  output logic signed [lsf_pkg::OutW-1:0]     y_fitted_o,
  output logic signed [lsf_pkg::OutW-1:0]     slope_o,
  output logic signed [lsf_pkg::OutW-1:0]     intercept_o,
  output logic [lsf_pkg::StatusW-1:0]         fit_status_o,
  output logic                                last_result_o
);

  localparam int W     = lsf_pkg::ArithW;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int SX_W  = COORD_WIDTH + CNT_W;
  localparam int SXX_W = 2 * COORD_WIDTH + CNT_W - 1;
  localparam int FRAC  = lsf_pkg::SlopeFrac;
  localparam int OW    = lsf_pkg::OutW;

  typedef enum logic [3:0] {
    S_LOAD,
    S_MUL_NXX,
    S_MUL_SXSX,
    S_MUL_NXY,
    S_MUL_SXSY,
    S_MUL_XXY,
    S_MUL_SXXY,
    S_DIV_SLOPE,
    S_DIV_ICPT,
    S_MEM_RD,
    S_MUL_FIT,
    S_EMIT
  } state_e;

  state_e state_q;
  logic   issued_q;

  // Point memory
  logic signed [COORD_WIDTH-1:0] x_mem [MAX_POINTS];
  logic signed [COORD_WIDTH-1:0] y_mem [MAX_POINTS];
  logic signed [COORD_WIDTH-1:0] rd_x_q;
  logic signed [COORD_WIDTH-1:0] rd_y_q;

  // Running sums
  logic [CNT_W-1:0]        count_q;
  logic signed [SX_W-1:0]  sum_x_q;
  logic signed [SX_W-1:0]  sum_y_q;
  logic signed [SXX_W-1:0] sum_xx_q;
  logic signed [SXX_W-1:0] sum_xy_q;
  logic                    ovf_q;

  // Fit registers
  logic signed [W-1:0]  tmp_q;
  logic signed [W-1:0]  den_q;
  logic signed [W-1:0]  numa_q;
  logic signed [W-1:0]  numb_q;
  logic signed [OW-1:0] slope_q;
  logic signed [OW-1:0] icpt_q;
  logic signed [OW-1:0] fit_q;
  logic                 degen_q;
  lsf_pkg::status_e     status_q;
  logic [IDX_W-1:0]     idx_q;
  logic                 out_valid_q;

  lsf_pkg::unit_req_t req;
  lsf_pkg::unit_rsp_t rsp;

  logic                          in_acc;
  logic                          room;
  logic signed [2*COORD_WIDTH-1:0] prod_xx;
  logic signed [2*COORD_WIDTH-1:0] prod_xy;
  logic signed [W-1:0]           n_ext;
  logic signed [W-1:0]           sx_ext;
  logic signed [W-1:0]           sy_ext;
  logic signed [W-1:0]           sxx_ext;
  logic signed [W-1:0]           sxy_ext;
  logic signed [W-1:0]           diff;
  logic signed [W-1:0]           fit_trunc;
  logic signed [W:0]             fit_sum;
  logic                          is_last;

  assign in_stall_o = (state_q != S_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign room       = (count_q < CNT_W'(MAX_POINTS));
  assign prod_xx    = x_value_i * x_value_i;
  assign prod_xy    = x_value_i * y_value_i;

  assign n_ext   = signed'(W'(count_q));
  assign sx_ext  = W'(sum_x_q);
  assign sy_ext  = W'(sum_y_q);
  assign sxx_ext = W'(sum_xx_q);
  assign sxy_ext = W'(sum_xy_q);
  assign diff    = tmp_q - rsp.result;

  // Truncate slope*x / 2^FRAC toward zero, then add the intercept.
  assign fit_trunc = rsp.result[W-1] ? (rsp.result + W'((1 << FRAC) - 1)) >>> FRAC
                                     : rsp.result >>> FRAC;
  assign fit_sum   = (W+1)'(fit_trunc) + (W+1)'(icpt_q);
  assign is_last   = (CNT_W'(idx_q) + CNT_W'(1) == count_q);

  // Operand selection for the shared unit
  always_comb begin
    req.start = 1'b0;
    req.op    = lsf_pkg::OP_MUL;
    req.a     = '0;
    req.b     = '0;
    case (state_q)
      S_MUL_NXX: begin
        req.a = n_ext;   req.b = sxx_ext;
      end
      S_MUL_SXSX: begin
        req.a = sx_ext;  req.b = sx_ext;
      end
      S_MUL_NXY: begin
        req.a = n_ext;   req.b = sxy_ext;
      end
      S_MUL_SXSY: begin
        req.a = sx_ext;  req.b = sy_ext;
      end
      S_MUL_XXY: begin
        req.a = sxx_ext; req.b = sy_ext;
      end
      S_MUL_SXXY: begin
        req.a = sx_ext;  req.b = sxy_ext;
      end
      S_DIV_SLOPE: begin
        req.op = lsf_pkg::OP_DIV;
        req.a  = numa_q <<< FRAC;
        req.b  = den_q;
      end
      S_DIV_ICPT: begin
        req.op = lsf_pkg::OP_DIV;
        req.a  = numb_q;
        req.b  = den_q;
      end
      S_MUL_FIT: begin
        req.a = W'(slope_q);
        req.b = W'(rd_x_q);
      end
      default: begin
        req.a = '0;
      end
    endcase
    req.start = !issued_q && (state_q != S_LOAD) && (state_q != S_MEM_RD) &&
                (state_q != S_EMIT) && !(state_q == S_MUL_FIT && degen_q);
  end

  lsf_seq_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // Point memory: write while loading, read one entry per result
  always_ff @(posedge clk_i) begin
    if (in_acc && room) begin
      x_mem[count_q[IDX_W-1:0]] <= x_value_i;
      y_mem[count_q[IDX_W-1:0]] <= y_value_i;
    end
    if (state_q == S_MEM_RD) begin
      rd_x_q <= x_mem[idx_q];
      rd_y_q <= y_mem[idx_q];
    end
  end

  // Sequencer with sums and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      issued_q    <= 1'b0;
      count_q     <= '0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      sum_xx_q    <= '0;
      sum_xy_q    <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      degen_q     <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (req.start) begin
        issued_q <= 1'b1;
      end
      case (state_q)
        S_LOAD: begin
          if (in_acc) begin
            // Accumulate while there is room, flag the rest
            if (room) begin
              count_q  <= count_q + CNT_W'(1);
              sum_x_q  <= sum_x_q + SX_W'(x_value_i);
              sum_y_q  <= sum_y_q + SX_W'(y_value_i);
              sum_xx_q <= sum_xx_q + SXX_W'(prod_xx);
              sum_xy_q <= sum_xy_q + SXX_W'(prod_xy);
            end else begin
              ovf_q <= 1'b1;
            end
            if (last_point_i) begin
              state_q <= S_MUL_NXX;
            end
          end
        end
        S_MUL_NXX, S_MUL_NXY, S_MUL_XXY: begin
          if (rsp.done) begin
            issued_q <= 1'b0;
            tmp_q    <= rsp.result;
            state_q  <= state_e'(state_q + 4'd1);
          end
        end
        S_MUL_SXSX: begin
          if (rsp.done) begin
            issued_q <= 1'b0;
            den_q    <= diff;
            state_q  <= S_MUL_NXY;
          end
        end
        S_MUL_SXSY: begin
          if (rsp.done) begin
            issued_q <= 1'b0;
            numa_q   <= diff;
            state_q  <= S_MUL_XXY;
          end
        end
        S_MUL_SXXY: begin
          if (rsp.done) begin
            issued_q <= 1'b0;
            numb_q   <= diff;
            idx_q    <= '0;
            // Zero or negative denominator: degenerate, all fit values zero
            if (den_q <= 0) begin
              degen_q  <= 1'b1;
              status_q <= lsf_pkg::STATUS_DEGEN;
              slope_q  <= '0;
              icpt_q   <= '0;
              state_q  <= S_MEM_RD;
            end else begin
              degen_q  <= 1'b0;
              status_q <= ovf_q ? lsf_pkg::STATUS_DROPPED : lsf_pkg::STATUS_OK;
              state_q  <= S_DIV_SLOPE;
            end
          end
        end
        S_DIV_SLOPE: begin
          if (rsp.done) begin
            issued_q <= 1'b0;
            slope_q  <= lsf_pkg::sat32((W+1)'(rsp.result));
            state_q  <= S_DIV_ICPT;
          end
        end
        S_DIV_ICPT: begin
          if (rsp.done) begin
            issued_q <= 1'b0;
            icpt_q   <= lsf_pkg::sat32((W+1)'(rsp.result));
            state_q  <= S_MEM_RD;
          end
        end
        S_MEM_RD: begin
          state_q <= S_MUL_FIT;
        end
        S_MUL_FIT: begin
          if (degen_q) begin
            fit_q       <= '0;
            out_valid_q <= 1'b1;
            state_q     <= S_EMIT;
          end else if (rsp.done) begin
            issued_q    <= 1'b0;
            fit_q       <= lsf_pkg::sat32(fit_sum);
            out_valid_q <= 1'b1;
            state_q     <= S_EMIT;
          end
        end
        S_EMIT: begin
          // Hold the word until taken, then advance or finish the set
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            if (is_last) begin
              count_q  <= '0;
              sum_x_q  <= '0;
              sum_y_q  <= '0;
              sum_xx_q <= '0;
              sum_xy_q <= '0;
              ovf_q    <= 1'b0;
              state_q  <= S_LOAD;
            end else begin
              idx_q   <= idx_q + IDX_W'(1);
              state_q <= S_MEM_RD;
            end
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign point_index_o = lsf_pkg::IndexW'(idx_q);
  assign x_echo_o      = rd_x_q;
  assign y_observed_o  = rd_y_q;
  assign y_fitted_o    = fit_q;
  assign slope_o       = slope_q;
  assign intercept_o   = icpt_q;
  assign fit_status_o  = status_q;
  assign last_result_o = is_last;

  // Loading and emitting never overlap
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("input ready while a result word is pending");

  // The shared unit only finishes an operation that was issued
  a_done_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> issued_q)
    else $error("shared unit done without a pending operation");

  // Degenerate fit gives zero slope, intercept and fit
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fit_status_o == lsf_pkg::STATUS_DEGEN |->
      slope_o == '0 && y_fitted_o == '0 && intercept_o == '0)
    else $error("degenerate result with nonzero fit values");

  // Taking the last word of a set reopens the input
  a_reopen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_result_o && !out_stall_i |=> !in_stall_o)
    else $error("input not reopened after last result word");

endmodule
